@@ hw/rtl/mrra_pkg.sv @@
// mrra_pkg: shared types and constants of the mouse report accumulator
// holds the event and report beat layouts, command codes and status codes
// no dependencies
package mrra_pkg;

    // field widths of the event and report beats
    localparam int CMD_W     = 4;
    localparam int BTN_IDX_W = 3;
    localparam int MASK_W    = 8;
    localparam int MOVE_W    = 16;
    localparam int SCROLL_W  = 8;
    localparam int RPT_BTN_W = 5;
    localparam int STATUS_W  = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PRESS_ONE    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE_ONE  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_PRESS_MASK   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_RELEASE_MASK = 4'd3;
    localparam logic [CMD_W-1:0] CMD_MOVE_SET     = 4'd4;
    localparam logic [CMD_W-1:0] CMD_MOVE_ADD     = 4'd5;
    localparam logic [CMD_W-1:0] CMD_SCROLL_SET   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_SCROLL_ADD   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_CLEAR        = 4'd8;

    // status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_BAD_INDEX = 2'd1,
        STS_NO_PRESS  = 2'd2
    } t_status;

    // one input event beat
    typedef struct packed {
        logic [CMD_W-1:0]            cmd;
        logic [BTN_IDX_W-1:0]        button;
        logic [MASK_W-1:0]           button_mask;
        logic signed [MOVE_W-1:0]    dx;
        logic signed [MOVE_W-1:0]    dy;
    } t_evt;

    // one report beat
    typedef struct packed {
        logic [STATUS_W-1:0]         status;
        logic [RPT_BTN_W-1:0]        buttons;
        logic signed [MOVE_W-1:0]    move_x;
        logic signed [MOVE_W-1:0]    move_y;
        logic signed [SCROLL_W-1:0]  scroll_x;
        logic signed [SCROLL_W-1:0]  scroll_y;
    } t_rpt;

endpackage

@@ hw/rtl/mrra_if.sv @@
// mrra_if: valid/ready channels for event beats and report beats
// depends on mrra_pkg for the beat layouts
interface mrra_evt_if;
    import mrra_pkg::*;

    logic valid;
    logic ready;
    t_evt data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface mrra_rpt_if;
    import mrra_pkg::*;

    logic valid;
    logic ready;
    t_rpt data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

@@ hw/rtl/mouse_report_refcount_accumulator.sv @@
// mouse_report_refcount_accumulator: pointer report builder with per-button press counts
// depends on mrra_pkg and the channel interfaces in mrra_if
//
// usage:
//   i_evt carries one event beat (command, button index, button mask, dx, dy)
//   o_rpt returns exactly one report beat per event: status plus the report
//   (buttons, movement, scroll) as it stands after that event
//   stages: each event passes the event register, then the report register
//   throughput: one event per cycle unless o_rpt stalls; state update is a single
//   pass of short logic from the event register into the state and report registers
//   stall: while a report beat waits on o_rpt.ready the event register can
//   still take one more beat; i_evt.ready drops only when both are full
//   reset: synchronous, active low; clears press counts, held mask, report
//   buttons, movement, scroll and both stage valids
//   press counts saturate at 2^COUNT_BITS-1; movement and scroll wrap
module mouse_report_refcount_accumulator #(
    parameter int NUM_BUTTONS = 5,
    parameter int COUNT_BITS  = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mrra_evt_if.sink   i_evt,
    mrra_rpt_if.source o_rpt
);
    import mrra_pkg::*;

    localparam logic [BTN_IDX_W:0] NUM_BTN_L = (BTN_IDX_W+1)'(NUM_BUTTONS);
    localparam int                 EXT_W     = RPT_BTN_W + NUM_BUTTONS;

    // event stage
    logic                   r_evt_vld;
    t_evt                   r_evt;
    // report stage
    logic                   r_rpt_vld;
    t_rpt                   r_rpt;
    // block state
    logic [COUNT_BITS-1:0]  r_cnt [NUM_BUTTONS];
    logic [COUNT_BITS-1:0]  n_cnt [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] r_held, n_held;
    logic [NUM_BUTTONS-1:0] r_rpt_btn, n_rpt_btn;
    logic [MOVE_W-1:0]      r_acc_x, n_acc_x;
    logic [MOVE_W-1:0]      r_acc_y, n_acc_y;
    logic [SCROLL_W-1:0]    r_acc_sx, n_acc_sx;
    logic [SCROLL_W-1:0]    r_acc_sy, n_acc_sy;

    logic                   w_adv;
    logic [NUM_BUTTONS-1:0] w_press;
    logic [NUM_BUTTONS-1:0] w_rel;
    logic [NUM_BUTTONS-1:0] w_cnt_zero;
    logic                   w_any_act;
    logic                   w_bad_idx;
    logic                   w_single;
    t_status                w_status;
    logic [EXT_W-1:0]       w_btn_ext;

    // handshake: the event stage moves on whenever the report slot is free
    assign w_adv       = r_evt_vld && (!r_rpt_vld || o_rpt.ready);
    assign i_evt.ready = !r_evt_vld || w_adv;
    assign o_rpt.valid = r_rpt_vld;
    assign o_rpt.data  = r_rpt;

    // per-button lanes: press and release decode and count update
    always_comb begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            w_press[i] = (r_evt.cmd == CMD_PRESS_ONE && r_evt.button == BTN_IDX_W'(i))
                      || (r_evt.cmd == CMD_PRESS_MASK && r_evt.button_mask[i]);
            w_rel[i]   = (r_evt.cmd == CMD_RELEASE_ONE && r_evt.button == BTN_IDX_W'(i))
                      || (r_evt.cmd == CMD_RELEASE_MASK && r_evt.button_mask[i]);
            w_cnt_zero[i] = (r_cnt[i] == '0);
            n_cnt[i]      = r_cnt[i];
            n_held[i]     = r_held[i];
            if (w_press[i]) begin
                if (r_cnt[i] != '1) begin
                    n_cnt[i] = r_cnt[i] + 1'b1;
                end
                n_held[i] = 1'b1;
            end else if (w_rel[i] && !w_cnt_zero[i]) begin
                n_cnt[i] = r_cnt[i] - 1'b1;
                if (r_cnt[i] == COUNT_BITS'(1)) begin
                    n_held[i] = 1'b0;
                end
            end
        end
    end

    // status of single-button commands
    always_comb begin
        w_any_act = |(w_press | (w_rel & ~w_cnt_zero));
        w_single  = (r_evt.cmd == CMD_PRESS_ONE) || (r_evt.cmd == CMD_RELEASE_ONE);
        w_bad_idx = ({1'b0, r_evt.button} >= NUM_BTN_L);
        w_status  = STS_OK;
        if (w_single && w_bad_idx) begin
            w_status = STS_BAD_INDEX;
        end else if (r_evt.cmd == CMD_RELEASE_ONE && |(w_rel & w_cnt_zero)) begin
            w_status = STS_NO_PRESS;
        end
    end

    // report body: buttons, movement and scroll
    always_comb begin
        n_rpt_btn = r_rpt_btn;
        n_acc_x   = r_acc_x;
        n_acc_y   = r_acc_y;
        n_acc_sx  = r_acc_sx;
        n_acc_sy  = r_acc_sy;
        if (w_any_act) begin
            n_rpt_btn = n_held;
        end
        case (r_evt.cmd)
            CMD_MOVE_SET: begin
                n_acc_x = r_evt.dx;
                n_acc_y = r_evt.dy;
            end
            CMD_MOVE_ADD: begin
                n_acc_x = r_acc_x + r_evt.dx;
                n_acc_y = r_acc_y + r_evt.dy;
            end
            CMD_SCROLL_SET: begin
                n_acc_sx = r_evt.dx[SCROLL_W-1:0];
                n_acc_sy = r_evt.dy[SCROLL_W-1:0];
            end
            CMD_SCROLL_ADD: begin
                n_acc_sx = r_acc_sx + r_evt.dx[SCROLL_W-1:0];
                n_acc_sy = r_acc_sy + r_evt.dy[SCROLL_W-1:0];
            end
            CMD_CLEAR: begin
                n_rpt_btn = '0;
                n_acc_x   = '0;
                n_acc_y   = '0;
                n_acc_sx  = '0;
                n_acc_sy  = '0;
            end
            default: begin
            end
        endcase
    end

    // report buttons fit to the fixed report width
    assign w_btn_ext = EXT_W'(n_rpt_btn);

    // event stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evt_vld <= 1'b0;
        end else if (i_evt.ready) begin
            r_evt_vld <= i_evt.valid;
        end
        if (i_evt.valid && i_evt.ready) begin
            r_evt <= i_evt.data;
        end
    end

    // state and report stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_cnt[i] <= '0;
            end
            r_held    <= '0;
            r_rpt_btn <= '0;
            r_acc_x   <= '0;
            r_acc_y   <= '0;
            r_acc_sx  <= '0;
            r_acc_sy  <= '0;
            r_rpt_vld <= 1'b0;
        end else begin
            if (w_adv) begin
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    r_cnt[i] <= n_cnt[i];
                end
                r_held    <= n_held;
                r_rpt_btn <= n_rpt_btn;
                r_acc_x   <= n_acc_x;
                r_acc_y   <= n_acc_y;
                r_acc_sx  <= n_acc_sx;
                r_acc_sy  <= n_acc_sy;
                r_rpt_vld <= 1'b1;
            end else if (o_rpt.ready) begin
                r_rpt_vld <= 1'b0;
            end
        end
        if (w_adv) begin
            r_rpt.status   <= w_status;
            r_rpt.buttons  <= w_btn_ext[RPT_BTN_W-1:0];
            r_rpt.move_x   <= n_acc_x;
            r_rpt.move_y   <= n_acc_y;
            r_rpt.scroll_x <= n_acc_sx;
            r_rpt.scroll_y <= n_acc_sy;
        end
    end

endmodule

@@ hw/rtl/mrra_chk.sv @@
// mrra_chk: port-level checks of the mouse report accumulator
// depends on mrra_pkg; bound to mouse_report_refcount_accumulator below
module mrra_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_vld,
    input logic                          i_in_rdy,
    input logic                          i_out_vld,
    input logic                          i_out_rdy,
    input logic [mrra_pkg::STATUS_W-1:0] i_out_status
);
    import mrra_pkg::*;

    // a report beat held back by the receiver stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_vld && !i_out_rdy |=> i_out_vld)
        else $error("report beat dropped while stalled");

    // every accepted event is followed by an offered report beat
    a_evt_to_rpt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_vld && i_in_rdy |-> ##2 i_out_vld)
        else $error("no report beat after accepted event");

    // reset empties the report stage
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_vld)
        else $error("report beat valid right after reset");

    // only the three defined status codes appear
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_vld |-> (i_out_status == STS_OK || i_out_status == STS_BAD_INDEX
                       || i_out_status == STS_NO_PRESS))
        else $error("undefined status code");

endmodule

bind mouse_report_refcount_accumulator mrra_chk u_mrra_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_vld    (i_evt.valid),
    .i_in_rdy    (i_evt.ready),
    .i_out_vld   (o_rpt.valid),
    .i_out_rdy   (o_rpt.ready),
    .i_out_status(o_rpt.data.status)
);

@@ verif/tb_mouse_report_refcount_accumulator.sv @@
`timescale 1ns / 1ps
// tb_mouse_report_refcount_accumulator: self-checking bench for the mouse report accumulator
// drives event beats, predicts each report beat and compares it field by field
// depends on mrra_pkg, the channel interfaces in mrra_if and the top level rtl
module tb_mouse_report_refcount_accumulator;
    import mrra_pkg::*;

    localparam int NUM_BUTTONS  = 5;
    localparam int COUNT_BITS   = 8;
    localparam int COUNT_TOP    = (1 << COUNT_BITS) - 1;
    localparam int RANDOM_ITEMS = 1100;
    localparam int MAX_WAIT     = 5;

    // event waiting to be driven, optionally held back until all reports are back
    typedef struct {
        t_evt evt;
        bit   drain_first;
    } t_pending_evt;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mrra_evt_if evt_if();
    mrra_rpt_if rpt_if();

    mouse_report_refcount_accumulator #(
        .NUM_BUTTONS(NUM_BUTTONS),
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_evt  (evt_if),
        .o_rpt  (rpt_if)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_pending_evt evt_pending[$];
    t_rpt         expected_reports[$];
    t_rpt         report_want;
    int           fail_count = 0;
    int           evt_gap = 0;
    int           rpt_stall = 0;
    bit           burst_mode = 1'b0;

    // predicted state of the report builder
    logic [COUNT_BITS-1:0]  press_tally [NUM_BUTTONS] = '{default: '0};
    logic [NUM_BUTTONS-1:0] held_buttons = '0;
    logic [RPT_BTN_W-1:0]   shown_buttons = '0;
    logic [MOVE_W-1:0]      track_x = '0;
    logic [MOVE_W-1:0]      track_y = '0;
    logic [SCROLL_W-1:0]    wheel_x = '0;
    logic [SCROLL_W-1:0]    wheel_y = '0;

    function automatic t_status press_button(int idx);
        if (idx >= NUM_BUTTONS) return STS_BAD_INDEX;
        // count sticks at its top value, held bit is still set
        if (press_tally[idx] != COUNT_TOP[COUNT_BITS-1:0]) press_tally[idx]++;
        held_buttons[idx] = 1'b1;
        shown_buttons = held_buttons;
        return STS_OK;
    endfunction

    function automatic t_status release_button(int idx);
        if (idx >= NUM_BUTTONS) return STS_BAD_INDEX;
        if (press_tally[idx] == '0) return STS_NO_PRESS;
        press_tally[idx]--;
        if (press_tally[idx] == '0) held_buttons[idx] = 1'b0;
        shown_buttons = held_buttons;
        return STS_OK;
    endfunction

    // apply one event to the predicted state and return the report it yields
    function automatic t_rpt next_report(t_evt e);
        t_rpt    r;
        t_status sts;
        sts = STS_OK;
        case (e.cmd)
            CMD_PRESS_ONE:   sts = press_button(int'(e.button));
            CMD_RELEASE_ONE: sts = release_button(int'(e.button));
            CMD_PRESS_MASK: begin
                for (int i = 0; i < NUM_BUTTONS; i++)
                    if (e.button_mask[i]) void'(press_button(i));
            end
            CMD_RELEASE_MASK: begin
                for (int i = 0; i < NUM_BUTTONS; i++)
                    if (e.button_mask[i]) void'(release_button(i));
            end
            CMD_MOVE_SET: begin
                track_x = e.dx;
                track_y = e.dy;
            end
            CMD_MOVE_ADD: begin
                track_x = track_x + e.dx;
                track_y = track_y + e.dy;
            end
            CMD_SCROLL_SET: begin
                wheel_x = e.dx[SCROLL_W-1:0];
                wheel_y = e.dy[SCROLL_W-1:0];
            end
            CMD_SCROLL_ADD: begin
                wheel_x = wheel_x + e.dx[SCROLL_W-1:0];
                wheel_y = wheel_y + e.dy[SCROLL_W-1:0];
            end
            CMD_CLEAR: begin
                shown_buttons = '0;
                track_x = '0;
                track_y = '0;
                wheel_x = '0;
                wheel_y = '0;
            end
            default: ;
        endcase
        r.status   = sts;
        r.buttons  = shown_buttons;
        r.move_x   = track_x;
        r.move_y   = track_y;
        r.scroll_x = wheel_x;
        r.scroll_y = wheel_y;
        return r;
    endfunction

    // random event, mostly valid button indexes, every command reachable
    function automatic t_evt random_event();
        t_evt e;
        int   pick;
        e.dx          = MOVE_W'($urandom);
        e.dy          = MOVE_W'($urandom);
        e.button_mask = MASK_W'($urandom);
        if ($urandom_range(0, 9) == 0)
            e.button = BTN_IDX_W'($urandom_range(NUM_BUTTONS, (1 << BTN_IDX_W) - 1));
        else
            e.button = BTN_IDX_W'($urandom_range(0, NUM_BUTTONS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 22)      e.cmd = CMD_PRESS_ONE;
        else if (pick < 44) e.cmd = CMD_RELEASE_ONE;
        else if (pick < 52) e.cmd = CMD_PRESS_MASK;
        else if (pick < 60) e.cmd = CMD_RELEASE_MASK;
        else if (pick < 65) e.cmd = CMD_MOVE_SET;
        else if (pick < 75) e.cmd = CMD_MOVE_ADD;
        else if (pick < 80) e.cmd = CMD_SCROLL_SET;
        else if (pick < 90) e.cmd = CMD_SCROLL_ADD;
        else if (pick < 95) e.cmd = CMD_CLEAR;
        else                e.cmd = CMD_W'($urandom_range(CMD_CLEAR + 1, (1 << CMD_W) - 1));
        return e;
    endfunction

    task automatic add_event(logic [CMD_W-1:0] cmd, int button, int mask, int dx, int dy,
                             bit drain);
        t_pending_evt p;
        p.evt.cmd         = cmd;
        p.evt.button      = button[BTN_IDX_W-1:0];
        p.evt.button_mask = mask[MASK_W-1:0];
        p.evt.dx          = dx[MOVE_W-1:0];
        p.evt.dy          = dy[MOVE_W-1:0];
        p.drain_first     = drain;
        evt_pending.push_back(p);
    endtask

    // event driver: predicts on every accepted beat, then idles or presents the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            evt_if.valid <= 1'b0;
        end else begin
            if (evt_if.valid && evt_if.ready) begin
                expected_reports.push_back(next_report(evt_if.data));
                void'(evt_pending.pop_front());
                evt_gap = burst_mode ? 0 : $urandom_range(0, MAX_WAIT);
                if ($urandom_range(0, 63) == 0) burst_mode <= !burst_mode;
            end
            if (evt_if.valid && !evt_if.ready) begin
                // hold the beat until taken
            end else if (evt_gap > 0) begin
                evt_gap--;
                evt_if.valid <= 1'b0;
            end else if (evt_pending.size() > 0 &&
                         (!evt_pending[0].drain_first || expected_reports.size() == 0)) begin
                evt_if.valid <= 1'b1;
                evt_if.data  <= evt_pending[0].evt;
            end else begin
                evt_if.valid <= 1'b0;
            end
        end
    end

    // report monitor: checks each beat against the oldest prediction, stalls at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rpt_if.ready <= 1'b0;
        end else begin
            if (rpt_if.valid && rpt_if.ready) begin
                if (expected_reports.size() == 0) begin
                    $error("report beat with no event outstanding");
                    fail_count++;
                end else begin
                    report_want = expected_reports.pop_front();
                    if (rpt_if.data.status !== report_want.status) begin
                        $error("status: expected %0d, got %0d",
                               report_want.status, rpt_if.data.status);
                        fail_count++;
                    end
                    if (rpt_if.data.buttons !== report_want.buttons) begin
                        $error("buttons: expected %b, got %b",
                               report_want.buttons, rpt_if.data.buttons);
                        fail_count++;
                    end
                    if (rpt_if.data.move_x !== report_want.move_x) begin
                        $error("move_x: expected %0d, got %0d",
                               report_want.move_x, rpt_if.data.move_x);
                        fail_count++;
                    end
                    if (rpt_if.data.move_y !== report_want.move_y) begin
                        $error("move_y: expected %0d, got %0d",
                               report_want.move_y, rpt_if.data.move_y);
                        fail_count++;
                    end
                    if (rpt_if.data.scroll_x !== report_want.scroll_x) begin
                        $error("scroll_x: expected %0d, got %0d",
                               report_want.scroll_x, rpt_if.data.scroll_x);
                        fail_count++;
                    end
                    if (rpt_if.data.scroll_y !== report_want.scroll_y) begin
                        $error("scroll_y: expected %0d, got %0d",
                               report_want.scroll_y, rpt_if.data.scroll_y);
                        fail_count++;
                    end
                end
                rpt_stall = burst_mode ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (rpt_stall > 0) begin
                rpt_stall--;
                rpt_if.ready <= 1'b0;
            end else begin
                rpt_if.ready <= 1'b1;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int n;
        int b;
        int k;
        evt_if.valid = 1'b0;
        evt_if.data  = '0;
        rpt_if.ready = 1'b0;
        i_rst_n      = 1'b0;

        // directed: button bookkeeping corners
        add_event(CMD_RELEASE_ONE, 0, 0, 0, 0, 1'b0);      // release without press
        add_event(CMD_PRESS_ONE, 7, 0, 0, 0, 1'b0);        // bad index, highest
        add_event(CMD_RELEASE_ONE, NUM_BUTTONS, 0, 0, 0, 1'b0);
        add_event(CMD_PRESS_ONE, 0, 0, 0, 0, 1'b0);
        add_event(CMD_PRESS_ONE, 0, 0, 0, 0, 1'b0);
        add_event(CMD_RELEASE_ONE, 0, 0, 0, 0, 1'b0);      // still held
        add_event(CMD_RELEASE_ONE, 0, 0, 0, 0, 1'b0);      // drops the bit
        add_event(CMD_RELEASE_ONE, 0, 0, 0, 0, 1'b0);
        add_event(CMD_PRESS_MASK, 0, 8'hFF, 0, 0, 1'b0);   // bits above buttons ignored
        add_event(CMD_CLEAR, 0, 0, 0, 0, 1'b0);            // held mask survives
        add_event(CMD_RELEASE_MASK, 0, 8'hE0, 0, 0, 1'b0); // nothing acted on
        add_event(CMD_RELEASE_MASK, 0, 8'h00, 0, 0, 1'b0);
        add_event(CMD_RELEASE_MASK, 0, 8'h1F, 0, 0, 1'b0);
        add_event(CMD_RELEASE_MASK, 0, 8'h1F, 0, 0, 1'b0); // all skipped
        add_event(CMD_PRESS_ONE, NUM_BUTTONS - 1, 0, 0, 0, 1'b0);
        // directed: movement and scroll extremes and wrap
        add_event(CMD_MOVE_SET, 0, 0, 32767, -32768, 1'b0);
        add_event(CMD_MOVE_ADD, 0, 0, 1, -1, 1'b0);
        add_event(CMD_MOVE_ADD, 0, 0, -1, -1, 1'b0);
        add_event(CMD_SCROLL_SET, 0, 0, 16'hAB7F, 16'h1280, 1'b0);
        add_event(CMD_SCROLL_ADD, 0, 0, 16'hFF01, 16'h00FF, 1'b0);
        add_event(CMD_CLEAR, 0, 0, 0, 0, 1'b0);
        add_event(CMD_MOVE_ADD, 0, 0, 16'hFFFF, 16'h8000, 1'b0);
        add_event('1, 7, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0); // unused commands
        add_event(CMD_W'(CMD_CLEAR + 1), 0, 0, 0, 0, 1'b0);

        // random traffic with one long press run that pins a count at its top
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                b = $urandom_range(0, NUM_BUTTONS - 1);
                for (k = 0; k < COUNT_TOP + 4; k++)
                    add_event(CMD_PRESS_ONE, b, $urandom, $urandom, $urandom, 1'b0);
                add_event(CMD_PRESS_MASK, 0, $urandom | (1 << b), $urandom, $urandom, 1'b0);
                for (k = 0; k < COUNT_TOP + 4; k++)
                    add_event(CMD_RELEASE_ONE, b, $urandom, $urandom, $urandom, k == 0);
            end
            evt_pending.push_back('{evt: random_event(), drain_first: (n % 300) == 0});
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (evt_pending.size() != 0 || expected_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #1000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
